// ===== rtl/rmq_pkg.sv =====
// shared types, constants and helpers for the rotation matrix to quaternion block
package rmq_pkg;

    localparam int ENT_W = 16;
    localparam int MAG_W = 17;
    localparam int QUO_W = 17;

    typedef enum logic [1:0] {
        PATH_TRACE = 2'd0,
        PATH_X     = 2'd1,
        PATH_Y     = 2'd2,
        PATH_Z     = 2'd3
    } path_t;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        path_t          path;
        logic           bad;
        logic [2:0]     neg;
        mag_t [2:0]     mag;
    } side_t;

    typedef struct packed {
        path_t              path;
        logic               bad;
        logic [2:0]         neg;
        logic [ENT_W-1:0]   lead;
    } dside_t;

    typedef struct packed {
        logic signed [ENT_W-1:0] qx;
        logic signed [ENT_W-1:0] qy;
        logic signed [ENT_W-1:0] qz;
        logic signed [ENT_W-1:0] qw;
        path_t                   path;
        logic                    bad;
    } res_t;

    localparam logic [ENT_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [ENT_W-1:0] SAT_NEG = 16'h8000;

    // signed, saturated term from magnitude and sign
    function automatic logic [ENT_W-1:0] sat_term(input logic neg,
                                                  input logic [QUO_W-1:0] mag,
                                                  input logic ovf);
        logic [ENT_W-1:0] low;
        low = mag[ENT_W-1:0];
        if (ovf || (mag[QUO_W-1:ENT_W-1] != '0))
            sat_term = neg ? SAT_NEG : SAT_POS;
        else
            sat_term = neg ? (~low + 16'd1) : low;
    endfunction

endpackage

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// top level: rotation matrix to unit quaternion, fully pipelined
//
// input channel: in_valid / in_ready with the nine matrix entries m00..m22,
// signed, FRAC_BITS fraction bits. output channel: out_valid / out_ready
// with qx, qy, qz, qw (saturated, same format), path_taken and bad_matrix.
// one result item for every input item, in order.
// stages in order: the prep register, the square-root pipeline (one bit
// per stage, SW bits, where SW is the root width, (max(FRAC_BITS,17) + 2 +
// FRAC_BITS + 1) / 2), the 18-stage divider (setup plus one quotient bit
// per stage) and the output register.
// throughput: one item per cycle while the skid entry is empty.
// a two-entry output register (output + skid) takes the item already on
// its way while out_ready is low; once the skid entry fills, in_ready
// drops and every stage holds, so nothing is lost or repeated.
// reset clears all valid bits; payload registers are not reset.
// bad_matrix: the root argument was not positive; quaternion is zero and
// path_taken still names the chosen leading component.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  m00,
    input  logic signed [15:0]  m01,
    input  logic signed [15:0]  m02,
    input  logic signed [15:0]  m10,
    input  logic signed [15:0]  m11,
    input  logic signed [15:0]  m12,
    input  logic signed [15:0]  m20,
    input  logic signed [15:0]  m21,
    input  logic signed [15:0]  m22,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  qx,
    output logic signed [15:0]  qy,
    output logic signed [15:0]  qz,
    output logic signed [15:0]  qw,
    output logic [1:0]          path_taken,
    output logic                bad_matrix
);

    // radicand is arg << FRAC_BITS, padded to an even width
    localparam int MW    = (FRAC_BITS > 17) ? FRAC_BITS : 17;
    localparam int AW    = MW + 2;
    localparam int RW    = AW + FRAC_BITS;
    localparam int RAD_W = RW + (RW % 2);
    localparam int SW    = RAD_W / 2;

    logic                   en;
    logic                   prep_v, sq_v, dv_v;
    logic [RAD_W-1:0]       prep_rad;
    side_t                  prep_side, sq_side;
    logic [SW-1:0]          sq_root;
    logic [2:0][QUO_W-1:0]  dv_quo;
    logic [2:0]             dv_ovf;
    dside_t                 dv_side;
    logic [ENT_W-1:0]       ta, tb, tc;
    res_t                   res_next;
    res_t                   out_reg, skid_reg;
    logic                   out_v_reg, skid_v_reg;
    logic                   push;

    // whole pipeline advances unless the skid entry is occupied
    assign en       = !skid_v_reg;
    assign in_ready = en;

    rmq_prep #(
        .FRAC_BITS (FRAC_BITS),
        .RAD_W     (RAD_W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .m00       (m00),
        .m01       (m01),
        .m02       (m02),
        .m10       (m10),
        .m11       (m11),
        .m12       (m12),
        .m20       (m20),
        .m21       (m21),
        .m22       (m22),
        .out_valid (prep_v),
        .rad       (prep_rad),
        .side      (prep_side)
    );

    rmq_sqrt #(
        .RAD_W     (RAD_W),
        .SW        (SW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_v),
        .rad       (prep_rad),
        .in_side   (prep_side),
        .out_valid (sq_v),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    rmq_div #(
        .FRAC_BITS (FRAC_BITS),
        .SW        (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v),
        .root      (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_v),
        .quo       (dv_quo),
        .ovf       (dv_ovf),
        .out_side  (dv_side)
    );

    // lane a/b/c back onto x/y/z/w according to the leading component
    always_comb
    begin
        ta = sat_term(dv_side.neg[0], dv_quo[0], dv_ovf[0]);
        tb = sat_term(dv_side.neg[1], dv_quo[1], dv_ovf[1]);
        tc = sat_term(dv_side.neg[2], dv_quo[2], dv_ovf[2]);

        res_next.path = dv_side.path;
        res_next.bad  = dv_side.bad;
        unique case (dv_side.path)
            PATH_TRACE:
            begin
                res_next.qx = ta;
                res_next.qy = tb;
                res_next.qz = tc;
                res_next.qw = dv_side.lead;
            end
            PATH_X:
            begin
                res_next.qx = dv_side.lead;
                res_next.qy = tb;
                res_next.qz = tc;
                res_next.qw = ta;
            end
            PATH_Y:
            begin
                res_next.qx = tc;
                res_next.qy = dv_side.lead;
                res_next.qz = tb;
                res_next.qw = ta;
            end
            PATH_Z:
            begin
                res_next.qx = tb;
                res_next.qy = tc;
                res_next.qz = dv_side.lead;
                res_next.qw = ta;
            end
            default:
            begin
                res_next.qx = '0;
                res_next.qy = '0;
                res_next.qz = '0;
                res_next.qw = '0;
            end
        endcase

        // bad matrix gives an all-zero quaternion
        if (dv_side.bad)
        begin
            res_next.qx = '0;
            res_next.qy = '0;
            res_next.qz = '0;
            res_next.qw = '0;
        end
    end

    // output register plus skid entry
    assign push = dv_v && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || out_ready)
        begin
            out_v_reg  <= skid_v_reg || push;
            skid_v_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ready)
            out_reg <= skid_v_reg ? skid_reg : res_next;
        else if (push)
            skid_reg <= res_next;
    end

    assign out_valid  = out_v_reg;
    assign qx         = out_reg.qx;
    assign qy         = out_reg.qy;
    assign qz         = out_reg.qz;
    assign qw         = out_reg.qw;
    assign path_taken = out_reg.path;
    assign bad_matrix = out_reg.bad;

    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry valid without output valid");

    // a full skid entry blocks the input
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> !in_ready)
        else $error("input accepted while skid entry full");

    // bad matrix results are all zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_matrix) |->
            (qx == '0) && (qy == '0) && (qz == '0) && (qw == '0))
        else $error("bad matrix with nonzero quaternion");

    // the trace branch always has a positive root argument
    a_trace_good: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (path_taken == PATH_TRACE)) |-> !bad_matrix)
        else $error("bad matrix flagged on trace branch");

endmodule

// ===== rtl/rmq_prep.sv =====
// front stage: branch choice, square-root radicand and lane numerators
module rmq_prep import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14,
    parameter int RAD_W     = 34
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [15:0]      m00,
    input  logic signed [15:0]      m01,
    input  logic signed [15:0]      m02,
    input  logic signed [15:0]      m10,
    input  logic signed [15:0]      m11,
    input  logic signed [15:0]      m12,
    input  logic signed [15:0]      m20,
    input  logic signed [15:0]      m21,
    input  logic signed [15:0]      m22,
    output logic                    out_valid,
    output logic [RAD_W-1:0]        rad,
    output side_t                   side
);

    localparam int MW = (FRAC_BITS > 17) ? FRAC_BITS : 17;
    localparam int AW = MW + 2;
    localparam logic signed [AW:0] ONE = (AW+1)'(1) << FRAC_BITS;

    logic signed [17:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [17:0] tr, sel;
    logic signed [17:0] da, db, dc;
    logic signed [AW:0] argv;
    path_t              path;
    logic               bad;
    logic [RAD_W-1:0]   rad_next;
    side_t              side_next;
    logic               v_reg;
    logic [RAD_W-1:0]   rad_reg;
    side_t              side_reg;

    assign e00 = {{2{m00[15]}}, m00};
    assign e01 = {{2{m01[15]}}, m01};
    assign e02 = {{2{m02[15]}}, m02};
    assign e10 = {{2{m10[15]}}, m10};
    assign e11 = {{2{m11[15]}}, m11};
    assign e12 = {{2{m12[15]}}, m12};
    assign e20 = {{2{m20[15]}}, m20};
    assign e21 = {{2{m21[15]}}, m21};
    assign e22 = {{2{m22[15]}}, m22};

    assign tr = e00 + e11 + e22;

    always_comb
    begin
        // ties keep the lower index
        if (!tr[17] && (tr != '0))
            path = PATH_TRACE;
        else if (e11 > e00)
            path = (e22 > e11) ? PATH_Z : PATH_Y;
        else
            path = (e22 > e00) ? PATH_Z : PATH_X;

        unique case (path)
            PATH_TRACE:
            begin
                sel = tr;
                da  = e21 - e12;
                db  = e02 - e20;
                dc  = e10 - e01;
            end
            PATH_X:
            begin
                sel = e00 - e11 - e22;
                da  = e21 - e12;
                db  = e10 + e01;
                dc  = e20 + e02;
            end
            PATH_Y:
            begin
                sel = e11 - e22 - e00;
                da  = e02 - e20;
                db  = e21 + e12;
                dc  = e01 + e10;
            end
            PATH_Z:
            begin
                sel = e22 - e00 - e11;
                da  = e10 - e01;
                db  = e02 + e20;
                dc  = e12 + e21;
            end
            default:
            begin
                sel = tr;
                da  = '0;
                db  = '0;
                dc  = '0;
            end
        endcase

        argv = {{(AW+1-18){sel[17]}}, sel} + ONE;
        bad  = (path != PATH_TRACE) && (argv[AW] || (argv == '0));
        rad_next = bad ? '0 : RAD_W'({argv[AW-1:0], {FRAC_BITS{1'b0}}});

        side_next.path   = path;
        side_next.bad    = bad;
        side_next.neg    = {dc[17], db[17], da[17]};
        side_next.mag[0] = da[17] ? MAG_W'(-da) : da[MAG_W-1:0];
        side_next.mag[1] = db[17] ? MAG_W'(-db) : db[MAG_W-1:0];
        side_next.mag[2] = dc[17] ? MAG_W'(-dc) : dc[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;

endmodule

// ===== rtl/rmq_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module rmq_sqrt import rmq_pkg::*; #(
    parameter int RAD_W = 34,
    parameter int SW    = RAD_W / 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    rad,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [SW-1:0]       root,
    output side_t               out_side
);

    localparam int RMW = SW + 3;

    logic             v_reg    [SW];
    logic [RMW-1:0]   rem_reg  [SW];
    logic [SW-1:0]    root_reg [SW];
    logic [RAD_W-1:0] rad_reg  [SW];
    side_t            side_reg [SW];

    for (genvar k = 0; k < SW; k++)
    begin : g_stg
        logic [RMW-1:0]   rem_in, cur, trial, rem_next;
        logic [SW-1:0]    root_in, root_next;
        logic [RAD_W-1:0] rad_in;
        logic             v_in;
        side_t            side_in;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign v_in    = in_valid;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign v_in    = v_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign cur   = {rem_in[RMW-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};

        always_comb
        begin
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_in[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_in[SW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_in << 2;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[SW-1];
    assign root      = root_reg[SW-1];
    assign out_side  = side_reg[SW-1];

endmodule

// ===== rtl/rmq_div.sv =====
// three-lane pipelined restoring divider, (mag << frac + s) / 2s
module rmq_div import rmq_pkg::*; #(
    parameter int FRAC_BITS = 14,
    parameter int SW        = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [SW-1:0]           root,
    input  side_t                   in_side,
    output logic                    out_valid,
    output logic [2:0][QUO_W-1:0]   quo,
    output logic [2:0]              ovf,
    output dside_t                  out_side
);

    localparam int NW  = MAG_W + FRAC_BITS + 1;
    localparam int DW  = SW + 1 + QUO_W;
    localparam int CW  = ((NW > DW) ? NW : DW) + 1;
    localparam int LW  = ((SW + 1) > (ENT_W + 1)) ? (SW + 1) : (ENT_W + 1);
    localparam int NST = QUO_W + 1;

    logic                  v_reg    [NST];
    logic [2:0][CW-1:0]    rem_reg  [NST];
    logic [CW-1:0]         dv_reg   [NST];
    logic [2:0][QUO_W-1:0] q_reg    [NST];
    logic [2:0]            ovf_reg  [NST];
    dside_t                side_reg [NST];

    // setup stage: numerators, divisor, overflow and leading term
    logic [2:0][CW-1:0] num_next;
    logic [CW-1:0]      dv_next;
    logic [2:0]         ovf_next;
    logic [LW-1:0]      lead_full;
    dside_t             ds_next;

    always_comb
    begin
        dv_next = CW'({root, 1'b0});
        for (int l = 0; l < 3; l++)
        begin
            num_next[l] = CW'({in_side.mag[l], {FRAC_BITS{1'b0}}}) + CW'(root);
            ovf_next[l] = num_next[l] >= (dv_next << QUO_W);
        end
        lead_full       = (LW'(root) + LW'(1)) >> 1;
        ds_next.path    = in_side.path;
        ds_next.bad     = in_side.bad;
        ds_next.neg     = in_side.neg;
        ds_next.lead    = (lead_full[LW-1:ENT_W-1] != '0) ? SAT_POS : lead_full[ENT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num_next;
            dv_reg[0]   <= dv_next;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= ds_next;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar t = 1; t < NST; t++)
    begin : g_stg
        localparam int B = QUO_W - t;
        logic [2:0][CW-1:0]    rem_next;
        logic [2:0][QUO_W-1:0] q_next;
        logic [CW-1:0]         cmp;

        assign cmp = dv_reg[t-1] << B;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (rem_reg[t-1][l] >= cmp)
                begin
                    rem_next[l] = rem_reg[t-1][l] - cmp;
                    q_next[l]   = {q_reg[t-1][l][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = rem_reg[t-1][l];
                    q_next[l]   = {q_reg[t-1][l][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[t] <= 1'b0;
            else if (en)
                v_reg[t] <= v_reg[t-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[t]  <= rem_next;
                dv_reg[t]   <= dv_reg[t-1];
                q_reg[t]    <= q_next;
                ovf_reg[t]  <= ovf_reg[t-1];
                side_reg[t] <= side_reg[t-1];
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign quo       = q_reg[NST-1];
    assign ovf       = ovf_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

// ===== test/rotation_matrix_to_quaternion_top_tb.sv =====
// testbench for the rotation matrix to quaternion block: directed table, then random matrices
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_top_tb import rmq_pkg::*;;

    localparam int FRAC = 14;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 450;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] m00 = '0, m01 = '0, m02 = '0;
    logic signed [15:0] m10 = '0, m11 = '0, m12 = '0;
    logic signed [15:0] m20 = '0, m21 = '0, m22 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] qx, qy, qz, qw;
    logic [1:0] path_taken;
    logic bad_matrix;

    // one directed row: nine entries in row-major order, plus an optional typed result
    typedef struct packed {
        logic [0:8][15:0] ent;
        logic             typed;
        res_t             want;
    } matrix_row_t;

    res_t quat_queue[$];     // quaternions still owed by the block, oldest first
    int   fail_count = 0;
    int   quat_count = 0;
    int   path_seen[4] = '{0, 0, 0, 0};
    int   cycle_count = 0;
    bit   hold_req = 1'b0;   // raised once by the sender to ask for a long output stall
    bit   gaps_on = 1'b1;    // cleared for stretches with no idling

    rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .m00(m00), .m01(m01), .m02(m02),
        .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .out_valid(out_valid), .out_ready(out_ready),
        .qx(qx), .qy(qy), .qz(qz), .qw(qw),
        .path_taken(path_taken), .bad_matrix(bad_matrix)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit, reckoned far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // clamp to the 16-bit output range
    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // floor of the square root, one result bit at a time
    function automatic longint root_floor(input longint v);
        longint r, t;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // d / (2s) with FRAC fraction bits, nearest with ties away from zero, then clamped
    function automatic logic [15:0] half_ratio(input longint d, input longint s);
        longint mag, quo;
        mag = (d < 0) ? -d : d;
        quo = ((mag << FRAC) + s) / (2 * s);
        if (quo > 65536)
            quo = 65536;
        return clamp16((d < 0) ? -quo : quo);
    endfunction

    // expected quaternion for one matrix
    function automatic res_t quat_from_matrix(input logic [0:8][15:0] ent);
        longint m[3][3];
        longint one, tr, arg, s;
        logic [15:0] q[4];
        int i, j, k;
        res_t r;
        one = longint'(1) << FRAC;
        for (int a = 0; a < 9; a++)
            m[a / 3][a % 3] = longint'($signed(ent[a]));
        for (int a = 0; a < 4; a++)
            q[a] = '0;
        r.bad = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            r.path = PATH_TRACE;
            s = root_floor((tr + one) << FRAC);
            q[3] = clamp16((s + 1) >>> 1);
            q[0] = half_ratio(m[2][1] - m[1][2], s);
            q[1] = half_ratio(m[0][2] - m[2][0], s);
            q[2] = half_ratio(m[1][0] - m[0][1], s);
        end
        else
        begin
            // the leading axis moves only on a strictly larger diagonal entry
            i = 0;
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            case (i)
                0: r.path = PATH_X;
                1: r.path = PATH_Y;
                default: r.path = PATH_Z;
            endcase
            arg = m[i][i] - m[j][j] - m[k][k] + one;
            if (arg <= 0)
                r.bad = 1'b1;
            else
            begin
                s = root_floor(arg << FRAC);
                q[i] = clamp16((s + 1) >>> 1);
                q[3] = half_ratio(m[k][j] - m[j][k], s);
                q[j] = half_ratio(m[j][i] + m[i][j], s);
                q[k] = half_ratio(m[k][i] + m[i][k], s);
            end
        end
        r.qx = q[0];
        r.qy = q[1];
        r.qz = q[2];
        r.qw = q[3];
        return r;
    endfunction

    // offer one matrix after a random idle gap (possibly none) and hold it until the block takes it
    task automatic send_matrix(input logic [0:8][15:0] ent, input logic typed,
                               input res_t want);
        int gap;
        bit took;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <= ent;
        // in_ready is read at the falling edge, where nothing is moving
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        quat_queue.push_back(typed ? want : quat_from_matrix(ent));
    endtask

    // random matrix, in one of several shapes
    function automatic logic [0:8][15:0] random_matrix();
        logic [0:8][15:0] ent;
        int p[3];
        int shape, v;
        shape = $urandom_range(0, 9);
        if (shape <= 1)
        begin
            // any bit pattern at all
            for (int a = 0; a < 9; a++)
                ent[a] = 16'($urandom);
        end
        else if (shape <= 3)
        begin
            // entries inside the rotation range
            for (int a = 0; a < 9; a++)
                ent[a] = 16'($urandom_range(0, 32768) - 16384);
        end
        else if (shape <= 8)
        begin
            // signed permutation plus noise: near-rotations that reach every branch
            p[0] = $urandom_range(0, 2);
            p[1] = (p[0] + 1 + $urandom_range(0, 1)) % 3;
            p[2] = 3 - p[0] - p[1];
            for (int a = 0; a < 9; a++)
            begin
                v = $urandom_range(0, 800) - 400;
                if (p[a / 3] == a % 3)
                    v += $urandom_range(0, 1) ? 16384 : -16384;
                ent[a] = 16'(v);
            end
        end
        else
        begin
            // diagonal ties with a non-positive trace
            v = -$urandom_range(0, 16384);
            for (int a = 0; a < 9; a++)
                ent[a] = 16'($urandom_range(0, 32768) - 16384);
            ent[0] = 16'(v);
            ent[4] = 16'(v);
            ent[8] = $urandom_range(0, 1) ? 16'(v) : 16'(v - $urandom_range(1, 16384));
        end
        return ent;
    endfunction

    // compare one field and report a mismatch
    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d (0x%h) actual %0d (0x%h)", $time, name,
                     $signed(want), want, $signed(got), got);
        end
    endfunction

    // output monitor: a result counts at the rising edge that follows this falling edge
    always @(negedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (quat_queue.size() == 0)
            begin
                fail_count++;
                $display("%0t: result with none expected, actual qx %0d qy %0d qz %0d qw %0d",
                         $time, qx, qy, qz, qw);
            end
            else
            begin
                want = quat_queue.pop_front();
                check_field("qx", want.qx, qx);
                check_field("qy", want.qy, qy);
                check_field("qz", want.qz, qz);
                check_field("qw", want.qw, qw);
                check_field("path_taken", 16'(want.path), 16'(path_taken));
                check_field("bad_matrix", 16'(want.bad), 16'(bad_matrix));
                quat_count++;
                path_seen[path_taken]++;
            end
        end
    end

    // output side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        bit took;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !held)
            begin
                // long stall so the pipeline and skid fill and in_ready drops
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = gaps_on ? $urandom_range(0, 7) : 0;
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = out_valid;
                @(posedge clk);
            end while (!took);
        end
    end

    // stimulus
    initial
    begin
        matrix_row_t dir_rows[];
        res_t none;
        none = '0;
        dir_rows = new[14];
        // identity: w leads, exactly one
        dir_rows[0] = '{ent: {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                              16'sd0, 16'sd0, 16'sd16384},
                        typed: 1'b1,
                        want: '{qx: 16'sd0, qy: 16'sd0, qz: 16'sd0, qw: 16'sd16384,
                                path: PATH_TRACE, bad: 1'b0}};
        // zero matrix: trace not positive, x wins the three-way tie, root of one
        dir_rows[1] = '{ent: '0, typed: 1'b1,
                        want: '{qx: 16'sd8192, qy: 16'sd0, qz: 16'sd0, qw: 16'sd0,
                                path: PATH_X, bad: 1'b0}};
        // negative identity: x leads on a tie
        dir_rows[2] = '{ent: {-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                              16'sd0, 16'sd0, -16'sd16384}, typed: 1'b0, want: none};
        // half turn about y
        dir_rows[3] = '{ent: {-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                              16'sd0, 16'sd0, -16'sd16384}, typed: 1'b0, want: none};
        // half turn about z
        dir_rows[4] = '{ent: {-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                              16'sd0, 16'sd0, 16'sd16384}, typed: 1'b0, want: none};
        // x and y tie for the largest diagonal entry
        dir_rows[5] = '{ent: {16'sd0, 16'sd100, -16'sd200, 16'sd300, 16'sd0, 16'sd400,
                              -16'sd500, 16'sd600, -16'sd16384}, typed: 1'b0, want: none};
        // y and z tie
        dir_rows[6] = '{ent: {-16'sd16384, 16'sd700, 16'sd800, -16'sd900, 16'sd0, 16'sd1000,
                              16'sd1100, -16'sd1200, 16'sd0}, typed: 1'b0, want: none};
        // quarter turn about x
        dir_rows[7] = '{ent: {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd16384,
                              16'sd0, 16'sd16384, 16'sd0}, typed: 1'b0, want: none};
        // every entry at the top of the range
        dir_rows[8] = '{ent: {9{16'h7fff}}, typed: 1'b0, want: none};
        // every entry at the bottom of the range
        dir_rows[9] = '{ent: {9{16'h8000}}, typed: 1'b0, want: none};
        // small root with extreme off-diagonal entries: the other terms saturate
        dir_rows[10] = '{ent: {16'sd0, 16'h7fff, 16'h8000, 16'h7fff, 16'sd0, 16'h8000,
                               16'h8000, 16'h7fff, 16'sd0}, typed: 1'b0, want: none};
        // trace of one lsb
        dir_rows[11] = '{ent: {16'sd1, 16'sd5, -16'sd5, 16'sd7, 16'sd0, 16'sd3,
                               16'sd9, -16'sd2, 16'sd0}, typed: 1'b0, want: none};
        // trace exactly zero goes to the component branch
        dir_rows[12] = '{ent: {16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                               16'sd0, 16'sd0, 16'sd0}, typed: 1'b0, want: none};
        // alternating bit patterns
        dir_rows[13] = '{ent: {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                               16'haaaa, 16'h5555, 16'haaaa, 16'h5555},
                         typed: 1'b0, want: none};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            send_matrix(dir_rows[r].ent, dir_rows[r].typed, dir_rows[r].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // stretches with no idling on either side
            if (n % 100 == 50)
                gaps_on = 1'b0;
            if (n % 100 == 80)
                gaps_on = 1'b1;
            if (n == 150)
                hold_req = 1'b1;
            send_matrix(random_matrix(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (quat_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d quaternions: %0d trace, %0d x, %0d y, %0d z leading",
                 quat_count, path_seen[0], path_seen[1], path_seen[2], path_seen[3]);
        $display("included ties, saturation, full-range entries and a long output stall");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
